@@ rtl/rotated_rect_bounding_box_macros.svh @@
// Assertion macros shared by the rotated rectangle bounding box RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ROTATED_RECT_BOUNDING_BOX_MACROS_SVH
`define ROTATED_RECT_BOUNDING_BOX_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge outside reset
`define RRBB_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rrbb assertion failed: always");

// Consequent must hold in the same cycle as the antecedent
`define RRBB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrbb assertion failed: same cycle");

// Consequent must hold in the cycle after the antecedent
`define RRBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrbb assertion failed: next cycle");

`else

`define RRBB_ASSERT_ALWAYS(label, clk, rst, expr)
`define RRBB_ASSERT_SAME(label, clk, rst, ante, cons)
`define RRBB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/rrbb_pkg.sv @@
// Package for the rotated rectangle bounding box: default widths and the
// quarter-wave sine generator used to build the trig ROM at elaboration.
// No dependencies.
package rrbb_pkg;

   localparam int ANGLE_BITS_DEF     = 12;
   localparam int COORD_BITS_DEF     = 32;
   localparam int TRIG_FRAC_BITS_DEF = 14;

   // pi/2 in Q2.30 and 1.0 in Q2.30
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;

   // Number of odd Taylor terms past x (x^3 .. x^17)
   localparam int SERIES_TERMS = 8;

   // Term k is divided by (2k)(2k+1) through a reciprocal multiply:
   // ceil(2^RECIP_SHIFT / d). The dividend stays below 2^34 and the
   // reciprocal error below d, so the quotient is exact.
   localparam int RECIP_SHIFT = 48;
   localparam longint unsigned SERIES_RECIP [SERIES_TERMS] = '{
      ((64'd1 << RECIP_SHIFT) + 64'd5)   / 64'd6,
      ((64'd1 << RECIP_SHIFT) + 64'd19)  / 64'd20,
      ((64'd1 << RECIP_SHIFT) + 64'd41)  / 64'd42,
      ((64'd1 << RECIP_SHIFT) + 64'd71)  / 64'd72,
      ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110,
      ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156,
      ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210,
      ((64'd1 << RECIP_SHIFT) + 64'd271) / 64'd272
   };

   // Quarter-wave sine entry idx in Q1.frac, idx in 0 .. 2^qshift.
   // Angle in Q2.30 rounded half up, Taylor series with each term
   // truncated, clamped to [0, 1], then rounded half up to frac bits.
   function automatic logic [31:0] quarter_sine(input int unsigned idx,
                                                input int qshift,
                                                input int frac);
      longint unsigned quarter;
      longint unsigned i;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned r;
      logic [127:0]    wide;
      longint          sum;
      quarter = 64'd1 << qshift;
      i       = 64'(idx);
      if (i > quarter) i = quarter;
      x    = (HALF_PI_Q30 * i + (quarter >> 1)) >> qshift;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         wide = 128'((term * x2) >> 30) * 128'(SERIES_RECIP[k-1]);
         term = 64'(wide >> RECIP_SHIFT);
         if ((k & 1) == 1) sum = sum - longint'(term);
         else              sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (longint'(ONE_Q30) < sum) sum = longint'(ONE_Q30);
      r = ((64'(sum) << frac) + (ONE_Q30 >> 1)) >> 30;
      if (r > (64'd1 << frac)) r = 64'd1 << frac;
      return r[31:0];
   endfunction

endpackage

@@ rtl/rotated_rect_bounding_box.sv @@
// Rotated rectangle to axis-aligned bounding box, fully pipelined.
// Depends on rrbb_pkg and rotated_rect_bounding_box_macros.svh.
//
//  Channel  Dir  Handshake            Word contents (low bit first)
//  req      in   req_tvalid/tready    center_x, center_y, size_x, size_y, angle
//  rsp      out  rsp_tvalid/tready    box_min_x, box_min_y, box_width, box_height
//
// One word accepted per cycle while rsp is not stalled; its result passes the input
// reg, trig ROM read, multipliers, sum and round/saturate + output reg before it
// is offered on rsp.
// The trig ROM read and the four multipliers each take a stage of their own.
// Reset clears all stage valid bits; the pipeline is empty after reset.
// A stall on rsp freezes every stage, and req_tready drops in the same cycle.
`include "rotated_rect_bounding_box_macros.svh"

module rotated_rect_bounding_box #(
   parameter int ANGLE_BITS     = rrbb_pkg::ANGLE_BITS_DEF,
   parameter int COORD_BITS     = rrbb_pkg::COORD_BITS_DEF,
   parameter int TRIG_FRAC_BITS = rrbb_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // center_x, center_y, size_x, size_y (COORD_BITS each), angle, zero pad
   input  logic [((4*COORD_BITS+ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // box_min_x, box_min_y (COORD_BITS), box_width, box_height
   // (COORD_BITS-1 each), zero pad
   output logic [((4*COORD_BITS-2+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready
);

   localparam int QSHIFT  = ANGLE_BITS - 2;
   localparam int QUARTER = 1 << QSHIFT;
   localparam int IDX_W   = QSHIFT + 1;
   localparam int TRIG_W  = TRIG_FRAC_BITS + 1;
   localparam int PROD_W  = COORD_BITS + TRIG_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int HI_W    = SUM_W - TRIG_FRAC_BITS;
   localparam int M_W     = HI_W + 2;
   localparam int EXT_W   = COORD_BITS - 1;
   localparam int RSP_W   = ((4*COORD_BITS-2+7)/8)*8;
   localparam int PAD_W   = RSP_W - (4*COORD_BITS - 2);

   localparam logic [HI_W:0] EXT_MAX = {{(HI_W-EXT_W+1){1'b0}}, {EXT_W{1'b1}}};
   localparam logic signed [M_W-1:0] M_MIN =
      {{(M_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   // ---------------------------------------------------------------
   // Quarter-wave sine ROM, Q1.TRIG_FRAC_BITS, built at elaboration
   // ---------------------------------------------------------------
   logic [TRIG_W-1:0] trig_rom [QUARTER+1];

   for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
      assign trig_rom[g] =
         TRIG_W'(rrbb_pkg::quarter_sine(g, QSHIFT, TRIG_FRAC_BITS));
   end

   // Pipeline advances whenever the output register can take a word
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------------------------------------------------------
   // Stage A: input register
   // ---------------------------------------------------------------
   logic                         a_v_ff;
   logic signed [COORD_BITS-1:0] a_cx_ff, a_cy_ff, a_sx_ff, a_sy_ff;
   logic [ANGLE_BITS-1:0]        a_ang_ff;

   // ---------------------------------------------------------------
   // Stage B: magnitudes, ROM data
   // ---------------------------------------------------------------
   logic                         b_v_ff;
   logic signed [COORD_BITS-1:0] b_cx_ff, b_cy_ff;
   logic [COORD_BITS-1:0]        b_mx_ff, b_my_ff;
   logic [COORD_BITS-1:0]        b_mx_in, b_my_in;
   logic [TRIG_W-1:0]            b_tr_ff, b_tc_ff;
   logic [TRIG_W-1:0]            b_tr_in, b_tc_in;
   logic                         b_odd_ff;
   logic [IDX_W-1:0]             idx_r, idx_c;

   // Negative sizes fold to their magnitude; the most negative value
   // reads back as 2^(COORD_BITS-1) unsigned
   assign b_mx_in = a_sx_ff[COORD_BITS-1] ? COORD_BITS'(-a_sx_ff) : a_sx_ff;
   assign b_my_in = a_sy_ff[COORD_BITS-1] ? COORD_BITS'(-a_sy_ff) : a_sy_ff;

   // sin of the in-quadrant offset and of its complement
   assign idx_r   = {1'b0, a_ang_ff[QSHIFT-1:0]};
   assign idx_c   = IDX_W'(QUARTER) - idx_r;
   assign b_tr_in = trig_rom[idx_r];
   assign b_tc_in = trig_rom[idx_c];

   // ---------------------------------------------------------------
   // Stage C: four products
   // ---------------------------------------------------------------
   logic                         c_v_ff;
   logic signed [COORD_BITS-1:0] c_cx_ff, c_cy_ff;
   logic [PROD_W-1:0]            c_xa_ff, c_xb_ff, c_ya_ff, c_yb_ff;
   logic [TRIG_W-1:0]            sin_abs, cos_abs;

   // Odd quadrants swap sine and cosine
   assign sin_abs = b_odd_ff ? b_tc_ff : b_tr_ff;
   assign cos_abs = b_odd_ff ? b_tr_ff : b_tc_ff;

   // ---------------------------------------------------------------
   // Stage D: per-axis sums
   // ---------------------------------------------------------------
   logic                         d_v_ff;
   logic signed [COORD_BITS-1:0] d_cx_ff, d_cy_ff;
   logic [SUM_W-1:0]             d_px_ff, d_py_ff;

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   logic                         o_v_ff;
   logic [COORD_BITS-1:0]        o_minx_ff, o_miny_ff, o_minx_in, o_miny_in;
   logic [EXT_W-1:0]             o_w_ff, o_h_ff, o_w_in, o_h_in;

   // Extent: sum rounded half up from Q.14 to whole coordinate units, saturated
   function automatic logic [EXT_W-1:0] extent_of(input logic [SUM_W-1:0] p);
      logic [HI_W:0] w;
      w = {1'b0, p[SUM_W-1:TRIG_FRAC_BITS]} + {{HI_W{1'b0}}, p[TRIG_FRAC_BITS-1]};
      if (w > EXT_MAX) return {EXT_W{1'b1}};
      return w[EXT_W-1:0];
   endfunction

   // Least corner: center minus half the truncated extent, rounded up,
   // clamped at the bottom of the range
   function automatic logic [COORD_BITS-1:0] least_of(
      input logic [SUM_W-1:0] p, input logic signed [COORD_BITS-1:0] ctr);
      logic [HI_W:0]          h1;
      logic signed [M_W-1:0]  m;
      h1 = {1'b0, p[SUM_W-1:TRIG_FRAC_BITS]} + {{HI_W{1'b0}}, 1'b1};
      m  = M_W'(ctr) - $signed({2'b00, h1[HI_W:1]});
      if (m < M_MIN) return {1'b1, {(COORD_BITS-1){1'b0}}};
      return m[COORD_BITS-1:0];
   endfunction

   assign o_w_in    = extent_of(d_px_ff);
   assign o_h_in    = extent_of(d_py_ff);
   assign o_minx_in = least_of(d_px_ff, d_cx_ff);
   assign o_miny_in = least_of(d_py_ff, d_cy_ff);

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_tvalid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         o_v_ff <= d_v_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         a_cx_ff  <= req_tdata[0*COORD_BITS +: COORD_BITS];
         a_cy_ff  <= req_tdata[1*COORD_BITS +: COORD_BITS];
         a_sx_ff  <= req_tdata[2*COORD_BITS +: COORD_BITS];
         a_sy_ff  <= req_tdata[3*COORD_BITS +: COORD_BITS];
         a_ang_ff <= req_tdata[4*COORD_BITS +: ANGLE_BITS];

         b_cx_ff  <= a_cx_ff;
         b_cy_ff  <= a_cy_ff;
         b_mx_ff  <= b_mx_in;
         b_my_ff  <= b_my_in;
         b_tr_ff  <= b_tr_in;
         b_tc_ff  <= b_tc_in;
         b_odd_ff <= a_ang_ff[QSHIFT];

         c_cx_ff  <= b_cx_ff;
         c_cy_ff  <= b_cy_ff;
         c_xa_ff  <= PROD_W'(b_mx_ff) * PROD_W'(cos_abs);
         c_xb_ff  <= PROD_W'(b_my_ff) * PROD_W'(sin_abs);
         c_ya_ff  <= PROD_W'(b_mx_ff) * PROD_W'(sin_abs);
         c_yb_ff  <= PROD_W'(b_my_ff) * PROD_W'(cos_abs);

         d_cx_ff  <= c_cx_ff;
         d_cy_ff  <= c_cy_ff;
         d_px_ff  <= SUM_W'(c_xa_ff) + SUM_W'(c_xb_ff);
         d_py_ff  <= SUM_W'(c_ya_ff) + SUM_W'(c_yb_ff);

         o_minx_ff <= o_minx_in;
         o_miny_ff <= o_miny_in;
         o_w_ff    <= o_w_in;
         o_h_ff    <= o_h_in;
      end
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, o_h_ff, o_w_ff, o_miny_ff, o_minx_ff};

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // A finished sum always lands in the output register
   `RRBB_ASSERT_NEXT(a_sum_to_out, clock, reset, d_v_ff && adv, o_v_ff)
   // A stall freezes the inner stages
   `RRBB_ASSERT_NEXT(a_stall_hold, clock, reset, !adv,
      $stable(c_v_ff) && $stable(d_v_ff) && $stable(d_px_ff))
   // sin + cos of one quarter offset never falls more than one LSB below one
   `RRBB_ASSERT_SAME(a_trig_pair, clock, reset, b_v_ff,
      ({1'b0, b_tr_ff} + {1'b0, b_tc_ff}) >= (TRIG_W+1)'((1 << TRIG_FRAC_BITS) - 1))

endmodule

@@ tb/sv/rotated_rect_bounding_box_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for rotated_rect_bounding_box: a stimulus table, then random words;
// each result given or predicted via a local quarter-wave sine table. Depends on rrbb_pkg.

module rotated_rect_bounding_box_tb;

   localparam int AW      = rrbb_pkg::ANGLE_BITS_DEF;
   localparam int CW      = rrbb_pkg::COORD_BITS_DEF;
   localparam int FRAC    = rrbb_pkg::TRIG_FRAC_BITS_DEF;
   localparam int QSH     = AW - 2;
   localparam int QUARTER = 1 << QSH;
   localparam int REQ_W   = ((4*CW+AW+7)/8)*8;
   localparam int RSP_W   = ((4*CW-2+7)/8)*8;
   localparam int RAND_ITEMS  = 750;
   localparam int QUIET_LIMIT = 600;
   localparam int DRAIN_CYCLES = 20;
   localparam longint CMAX = (longint'(1) << (CW-1)) - 1;
   localparam longint CMIN = -(longint'(1) << (CW-1));

   typedef struct packed {
      logic [AW-1:0] angle;
      logic [CW-1:0] size_y;
      logic [CW-1:0] size_x;
      logic [CW-1:0] center_y;
      logic [CW-1:0] center_x;
   } rect_type;

   typedef struct packed {
      logic [CW-2:0] height;
      logic [CW-2:0] width;
      logic [CW-1:0] min_y;
      logic [CW-1:0] min_x;
   } box_type;

   typedef struct packed {
      logic     typed;
      box_type  box;
      rect_type rect;
   } row_type;

   typedef struct packed {
      logic [31:0] seq;
      box_type     box;
   } due_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;

   logic [FRAC:0] sine_lut [0:QUARTER];
   row_type rows [$];
   due_type pending_boxes [$];
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned words_sent = 0;
   int unsigned boxes_seen = 0;
   bit stim_done = 1'b0;

   rotated_rect_bounding_box uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // sin over one quadrant, index 0 .. QUARTER, in Q1.FRAC
   function automatic logic [FRAC:0] series_sine(input int unsigned idx);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned r;
      longint          acc;
      x    = (rrbb_pkg::HALF_PI_Q30 * idx + (QUARTER >> 1)) >> QSH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      // odd terms x^3 .. x^17, each truncated, signs alternate
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / longint'((2*k) * (2*k + 1));
         if (k[0]) acc = acc - longint'(term);
         else      acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(1) << 30) acc = longint'(1) << 30;
      r = ((longint'(acc) << FRAC) + (longint'(1) << 29)) >> 30;
      if (r > (longint'(1) << FRAC)) r = longint'(1) << FRAC;
      return r[FRAC:0];
   endfunction

   // one axis: extent rounded half up, least corner = center - half, saturated
   function automatic void axis_span(input longint unsigned mag_a, trig_a, mag_b, trig_b,
                                     input longint center,
                                     output logic [CW-1:0] least,
                                     output logic [CW-2:0] extent);
      longint unsigned prod;
      longint unsigned whole;
      longint unsigned span;
      longint unsigned half;
      longint          lo_edge;
      prod  = mag_a * trig_a + mag_b * trig_b;
      whole = prod >> FRAC;
      span  = whole + ((prod >> (FRAC-1)) & 64'd1);
      if (span > longint'(CMAX)) span = CMAX;
      half    = (whole + 1) >> 1;
      lo_edge = center - longint'(half);
      if (lo_edge < CMIN) lo_edge = CMIN;
      least  = lo_edge[CW-1:0];
      extent = span[CW-2:0];
   endfunction

   function automatic box_type bound_rect(input rect_type rc);
      box_type         bx;
      longint          sx;
      longint          sy;
      longint unsigned mag_x;
      longint unsigned mag_y;
      longint unsigned s_abs;
      longint unsigned c_abs;
      logic [QSH-1:0]  rem;
      sx    = longint'($signed(rc.size_x));
      sy    = longint'($signed(rc.size_y));
      mag_x = (sx < 0) ? -sx : sx;
      mag_y = (sy < 0) ? -sy : sy;
      rem   = rc.angle[QSH-1:0];
      // odd quadrants swap sine and cosine magnitudes
      if (rc.angle[QSH]) begin
         s_abs = sine_lut[QUARTER - rem];
         c_abs = sine_lut[rem];
      end else begin
         s_abs = sine_lut[rem];
         c_abs = sine_lut[QUARTER - rem];
      end
      axis_span(mag_x, c_abs, mag_y, s_abs, longint'($signed(rc.center_x)), bx.min_x, bx.width);
      axis_span(mag_x, s_abs, mag_y, c_abs, longint'($signed(rc.center_y)), bx.min_y,
                bx.height);
      return bx;
   endfunction

   task automatic add_row(input logic [CW-1:0] cx, cy, sx, sy, input logic [AW-1:0] ang,
                          input logic typed, input logic [CW-1:0] mx, my,
                          input logic [CW-2:0] wd, ht);
      row_type rw;
      rw.rect = '{angle: ang, size_y: sy, size_x: sx, center_y: cy, center_x: cx};
      rw.box  = '{height: ht, width: wd, min_y: my, min_x: mx};
      rw.typed = typed;
      rows.push_back(rw);
   endtask

   function automatic logic [CW-1:0] edge_coord();
      case ($urandom_range(0, 6))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'h0000_0001;
         4:       return 32'hFFFF_FFFF;
         5:       return 32'h8000_0001;
         default: return $urandom;
      endcase
   endfunction

   // near a quadrant boundary, wrapping around the full turn
   function automatic logic [AW-1:0] seam_angle();
      return AW'(QUARTER * $urandom_range(0, 3) + $urandom_range(0, 4) - 2);
   endfunction

   task automatic report_mismatch(input string what, input int unsigned seq,
                                  input logic [CW-1:0] got, want);
      $display("mismatch %s item %0d: got %h expected %h", what, seq, got, want);
      mismatch_count++;
   endtask

   // stimulus, acceptance and prediction
   initial begin
      row_type rw;
      rect_type rc;
      due_type due;
      int unsigned burst_left;
      int unsigned gap;

      for (int i = 0; i <= QUARTER; i++) sine_lut[i] = series_sine(i);

      // directed rows: zero, axis-aligned cases, negative sizes, saturation, rounding
      add_row(0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(32'h1_0000, 32'h2_0000, 32'h4_0000, 32'h2_0000, 0,
              1, 32'hFFFF_0000, 32'h1_0000, 31'h4_0000, 31'h2_0000);
      add_row(32'h1_0000, 32'h2_0000, 32'h4_0000, 32'h2_0000, 1024,
              1, 32'h0, 32'h0, 31'h2_0000, 31'h4_0000);
      add_row(32'h1_0000, 32'h2_0000, 32'h4_0000, 32'h2_0000, 2048,
              1, 32'hFFFF_0000, 32'h1_0000, 31'h4_0000, 31'h2_0000);
      add_row(32'h1_0000, 32'h2_0000, 32'h4_0000, 32'h2_0000, 3072,
              1, 32'h0, 32'h0, 31'h2_0000, 31'h4_0000);
      add_row(32'h1_0000, 32'h2_0000, 32'hFFFC_0000, 32'hFFFE_0000, 0,
              1, 32'hFFFF_0000, 32'h1_0000, 31'h4_0000, 31'h2_0000);
      add_row(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
              1, 32'hC000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      add_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
              1, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 0);
      add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0,
              1, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      add_row(0, 0, 1, 3, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 31'd1, 31'd3);
      add_row(0, 0, 1, 3, 1024, 1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 31'd3, 31'd1);
      add_row(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 2048,
              1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 31'd1, 31'd3);
      // predicted rows: off-axis angles, largest angle, big sizes at 45 degrees
      add_row(32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000, 32'h0003_0000, 1, 0, 0, 0, 0, 0);
      add_row(0, 0, 32'h0004_0000, 32'h0004_0000, 512, 0, 0, 0, 0, 0);
      add_row(0, 0, 32'h8000_0000, 32'h8000_0000, 512, 0, 0, 0, 0, 0);
      add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1536, 0, 0, 0, 0, 0);
      add_row(32'h1234_5678, 32'h8765_4321, 32'h0001_2345, 32'hFFFE_DCBA, 1023, 0, 0, 0, 0, 0);
      add_row(32'h0000_FFFF, 32'hFFFF_0001, 32'h0000_3FFF, 32'h0000_7FFF, 1025, 0, 0, 0, 0, 0);
      add_row(0, 0, 32'h0005_5555, 32'hFFFA_AAAB, 2047, 0, 0, 0, 0, 0);
      add_row(0, 0, 32'h0005_5555, 32'hFFFA_AAAB, 2049, 0, 0, 0, 0, 0);
      add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000, 32'h0200_0000, 2560, 0, 0, 0, 0, 0);
      add_row(0, 0, 32'h0001_0001, 32'h0002_0003, 3071, 0, 0, 0, 0, 0);
      add_row(0, 0, 32'h0001_0001, 32'h0002_0003, 3073, 0, 0, 0, 0, 0);
      add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 3584, 0, 0, 0, 0, 0);
      add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4095, 0, 0, 0, 0, 0);

      // random words: full range, small boxes, extremes, quadrant seams
      for (int n = 0; n < RAND_ITEMS; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               rc = '{angle: AW'($urandom), size_y: $urandom, size_x: $urandom,
                      center_y: $urandom, center_x: $urandom};
            end
            4, 5, 6: begin
               rc.center_x = 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
               rc.center_y = 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
               rc.size_x   = 32'($urandom_range(0, 32'h007F_FFFF)) - 32'h0040_0000;
               rc.size_y   = 32'($urandom_range(0, 32'h007F_FFFF)) - 32'h0040_0000;
               rc.angle    = AW'($urandom);
            end
            7: begin
               rc.center_x = edge_coord();
               rc.center_y = edge_coord();
               rc.size_x   = edge_coord();
               rc.size_y   = edge_coord();
               rc.angle    = seam_angle();
            end
            default: begin
               rc = '{angle: seam_angle(), size_y: $urandom, size_x: $urandom,
                      center_y: $urandom, center_x: $urandom};
            end
         endcase
         rows.push_back('{typed: 1'b0, box: '0, rect: rc});
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // sender: bursts of random length, random gaps in between
      burst_left = $urandom_range(1, 40);
      foreach (rows[i]) begin
         @(negedge clock);
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
         rw = rows[i];
         req_tvalid <= 1'b1;
         req_tdata  <= REQ_W'(rw.rect);
         do @(posedge clock); while (!req_tready);
         due.seq = words_sent;
         due.box = rw.typed ? rw.box : bound_rect(rw.rect);
         pending_boxes.push_back(due);
         words_sent++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      stim_done = 1'b1;

      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[rotated_rect_bounding_box] OK");
      end else begin
         $display("[rotated_rect_bounding_box] ERROR");
      end
      $finish;
   end

   // receiver: rotating stall pattern, redrawn whenever phase wraps to zero, sometimes none
   always @(negedge clock) begin
      logic [15:0] stall_pat;
      int unsigned phase;
      if (phase == 0) begin
         stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      phase = (phase + 1) % 64;
      rsp_tready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
   end

   // result check against the oldest expected box
   always @(posedge clock) begin
      box_type got;
      due_type due;
      if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[4*CW-3:0];
         if (pending_boxes.size() == 0) begin
            report_mismatch("unexpected result", boxes_seen, got.min_x, 0);
         end else begin
            due = pending_boxes.pop_front();
            if (got.min_x !== due.box.min_x)
               report_mismatch("box_min_x", due.seq, got.min_x, due.box.min_x);
            if (got.min_y !== due.box.min_y)
               report_mismatch("box_min_y", due.seq, got.min_y, due.box.min_y);
            if (got.width !== due.box.width)
               report_mismatch("box_width", due.seq, CW'(got.width), CW'(due.box.width));
            if (got.height !== due.box.height)
               report_mismatch("box_height", due.seq, CW'(got.height), CW'(due.box.height));
         end
         boxes_seen++;
      end
   end

   // watchdog: cycles with work outstanding but no word moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (stim_done && pending_boxes.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles, %0d results outstanding",
                  quiet_cycles, pending_boxes.size());
         $display("[rotated_rect_bounding_box] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
